[rtl/rational_arithmetic_unit_macros.svh]
// Assertion macros for the rational arithmetic unit.
// Used by the port checker; no other dependencies.
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
// Assert that a property holds on every clock edge outside reset.
`define RAU_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Assert the property also during reset.
`define RAU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

[rtl/rau_pkg.sv]
// Shared types and opcodes for the rational arithmetic unit.
// No dependencies.
package rau_pkg;
  typedef enum logic [2:0] {
    CMD_ADD  = 3'd0,
    CMD_SUB  = 3'd1,
    CMD_MUL  = 3'd2,
    CMD_DIV  = 3'd3,
    CMD_CMP  = 3'd4,
    CMD_NORM = 3'd5,
    CMD_RSV6 = 3'd6,
    CMD_RSV7 = 3'd7
  } cmd_t;
endpackage

[rtl/rational_arithmetic_unit.sv]
// Rational arithmetic unit top level: sequencer around one shared divider.
// Depends on rau_pkg and rau_divider.
// Each arithmetic item runs on the shared divider: x mod den, y mod den, a Euclid gcd
// loop on den and the remainder sum, then x, y and den divided by the gcd; compare and
// flagged items go straight to the result. One item at a time; not ready
// while busy or result held. Reset: rst synchronous, clears control; no other reset.
module rational_arithmetic_unit #(
  parameter int FRAC_WIDTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // cmd[2:0], a_neg, a_num, a_den, b_neg, b_num, b_den (low to high), zero fill
  input  logic [((4*FRAC_WIDTH+5+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // res_neg, res_num, res_den, a_greater, a_equal, overflow, div_zero, zero fill
  output logic [((2*FRAC_WIDTH+5+7)/8)*8-1:0] m_axis_tdata
);
  import rau_pkg::*;
  localparam int F  = FRAC_WIDTH;
  localparam int W  = 2 * F;
  localparam int IW = ((4*F+5+7)/8)*8;
  localparam int OW = ((2*F+5+7)/8)*8;
  localparam logic [W-1:0] NMAX = W'({F{1'b1}});

  typedef enum logic [3:0] {
    S_IDLE, S_SETUP, S_RX, S_RY, S_GCD, S_QX, S_QY, S_QD, S_FIN, S_OUT
  } state_t;

  state_t       state;
  logic [W-1:0] x, y, den, rx, g, qx, qy, dq;
  logic         neg, cx, res_neg, agt, aeq, ovf, dz;
  logic [F-1:0] res_num, res_den;
  logic         dstart, ddone;
  logic [W-1:0] dvd, dvs, dquot, drem;

  // input fields
  logic [2:0]   cmd;
  logic [F-1:0] an, ad, bn, bd;
  logic         as_, bs_;
  assign cmd = s_axis_tdata[2:0];
  assign an  = s_axis_tdata[4 +: F];
  assign ad  = s_axis_tdata[4+F +: F];
  assign bn  = s_axis_tdata[5+2*F +: F];
  assign bd  = s_axis_tdata[5+3*F +: F];
  assign as_ = s_axis_tdata[3] && (an != '0);
  assign bs_ = s_axis_tdata[4+2*F] && (bn != '0);

  logic [W-1:0] anbd, bnad, adbd, anbn, adbn;
  assign anbd = W'(an) * W'(bd);
  assign bnad = W'(bn) * W'(ad);
  assign adbd = W'(ad) * W'(bd);
  assign anbn = W'(an) * W'(bn);
  assign adbn = W'(ad) * W'(bn);

  logic [W-1:0] nsum;
  logic [W:0]   nsum_w;
  assign nsum_w = {1'b0, qx} + {1'b0, qy} + {{W{1'b0}}, cx};
  assign nsum   = nsum_w[W-1:0];

  logic [W-1:0] rsum;
  assign rsum = (rx >= den - drem) ? rx - (den - drem) : rx + drem;

  rau_divider #(.W(W)) u_div (
    .clk(clk), .rst(rst), .start(dstart), .dividend(dvd), .divisor(dvs),
    .done(ddone), .quot(dquot), .rem(drem)
  );

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata  = OW'({dz, ovf, aeq, agt, res_den, res_num, res_neg});

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      dstart <= 1'b0;
    end else begin
      dstart <= 1'b0;
      unique case (state)
        S_IDLE: if (s_axis_tvalid) begin
          {res_neg, res_num, res_den, agt, aeq, ovf, dz} <= '0;
          state <= S_OUT;
          if (cmd > CMD_NORM) begin
          end else if (ad == '0 || (cmd != CMD_NORM && bd == '0) ||
                       (cmd == CMD_DIV && bn == '0)) begin
            dz <= 1'b1;
          end else begin
            unique case (cmd)
              CMD_ADD, CMD_SUB: begin
                logic sb;
                sb = (cmd == CMD_SUB) ? (!bs_ && bn != '0) : bs_;
                den <= adbd;
                state <= S_SETUP;
                if (as_ == sb) begin
                  neg <= as_; x <= anbd; y <= bnad;
                end else if (anbd >= bnad) begin
                  neg <= as_; x <= anbd - bnad; y <= '0;
                end else begin
                  neg <= sb; x <= bnad - anbd; y <= '0;
                end
              end
              CMD_MUL: begin
                neg <= as_ != bs_; x <= anbn; y <= '0; den <= adbd; state <= S_SETUP;
              end
              CMD_DIV: begin
                neg <= as_ != bs_; x <= anbd; y <= '0; den <= adbn; state <= S_SETUP;
              end
              CMD_CMP: begin
                if (as_ != bs_) agt <= !as_;
                else begin
                  aeq <= anbd == bnad;
                  agt <= as_ ? (anbd < bnad) : (anbd > bnad);
                end
              end
              default: begin
                neg <= as_; x <= W'(an); y <= '0; den <= W'(ad); state <= S_SETUP;
              end
            endcase
          end
        end
        S_SETUP: begin
          dvd <= x; dvs <= den; dstart <= 1'b1; state <= S_RX;
        end
        S_RX: if (ddone) begin
          rx <= drem; dvd <= y; dstart <= 1'b1; state <= S_RY;
        end
        S_RY: if (ddone) begin
          // r = (x + y) mod den; gcd(den, r) by Euclid
          g <= den;
          if (rsum == '0) state <= S_QX;
          else begin dvd <= den; dvs <= rsum; dstart <= 1'b1; state <= S_GCD; end
          if (rsum == '0) begin dvd <= x; dvs <= den; dstart <= 1'b1; end
        end
        S_GCD: if (ddone) begin
          if (drem == '0) begin
            g <= dvs; dvd <= x; dstart <= 1'b1; state <= S_QX;
          end else begin
            dvd <= dvs; dvs <= drem; dstart <= 1'b1;
          end
        end
        S_QX: if (ddone) begin
          qx <= dquot; cx <= drem != '0; dvd <= y; dvs <= g; dstart <= 1'b1; state <= S_QY;
        end
        S_QY: if (ddone) begin
          qy <= dquot; cx <= cx || (drem != '0);
          dvd <= den; dvs <= g; dstart <= 1'b1; state <= S_QD;
        end
        S_QD: if (ddone) begin
          dq <= dquot; state <= S_FIN;
        end
        S_FIN: begin
          logic o;
          o = 1'b0;
          if (qx > NMAX || qy > NMAX || nsum_w > {1'b0, NMAX}) begin
            res_num <= F'(NMAX); o = 1'b1;
          end else res_num <= nsum[F-1:0];
          if (dq > NMAX) begin res_den <= F'(NMAX); o = 1'b1; end
          else res_den <= dq[F-1:0];
          res_neg <= neg;
          ovf <= o;
          if (x == '0 && y == '0) begin
            res_neg <= 1'b0; res_num <= '0; res_den <= F'(1);
          end
          state <= S_OUT;
        end
        S_OUT: if (m_axis_tready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  logic unused_in;
  assign unused_in = ^s_axis_tdata[IW-1:4*F+5];
endmodule

[rtl/rau_divider.sv]
// Restoring divider: one quotient bit per cycle.
// Depends on nothing; used by the top level for gcd remainders and quotients.
module rau_divider #(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quot,
  output logic [W-1:0] rem
);
  localparam int CW = $clog2(W + 1);
  logic [CW-1:0] cnt;
  logic          busy;
  logic [W-1:0]  dvs;
  logic [W:0]    trial;

  assign trial = {rem, quot[W-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
        quot <= dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        // shift one dividend bit in, subtract if it fits
        if (!trial[W]) begin
          rem <= trial[W-1:0];
          quot <= {quot[W-2:0], 1'b1};
        end else begin
          rem <= {rem[W-2:0], quot[W-1]};
          quot <= {quot[W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

[rtl/rau_checker.sv]
// Port checker for the rational arithmetic unit, bound to the top level.
// Depends on rational_arithmetic_unit_macros.svh.
`include "rational_arithmetic_unit_macros.svh"
module rau_checker #(
  parameter int OW = 48
) (
  input logic          clk,
  input logic          rst,
  input logic          s_axis_tvalid,
  input logic          s_axis_tready,
  input logic          m_axis_tvalid,
  input logic          m_axis_tready,
  input logic [OW-1:0] m_axis_tdata
);
  `RAU_ASSERT(a_excl, clk, rst, !(s_axis_tready && m_axis_tvalid), "ready while result held")
  `RAU_ASSERT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "valid dropped")
  `RAU_ASSERT(a_stab, clk, rst, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "data moved")
  `RAU_ASSERT(a_busy, clk, rst, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "ready after transfer")
endmodule

bind rational_arithmetic_unit rau_checker #(.OW($bits(m_axis_tdata))) u_rau_checker (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
